/* src/parat_pkg.sv */
package parat_pkg;

    localparam int ADDR_W   = 16;
    localparam int HANDLE_W = 4;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CHECK  = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } t_range;

    typedef struct packed {
        logic                accepted;
        logic [HANDLE_W-1:0] new_handle;
        logic                in_zone;
    } t_result;

endpackage

/* src/parat_ram.sv */
module parat_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  parat_pkg::t_range i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output parat_pkg::t_range o_rdata
);
    import parat_pkg::*;

    t_range r_mem [DEPTH];
    t_range r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/parat_ctrl.sv */
module parat_ctrl #(
    parameter int AREAS = 8,
    parameter int CW    = 4,
    parameter int IW    = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [parat_pkg::ADDR_W-1:0]      i_start_address,
    input  logic [parat_pkg::ADDR_W-1:0]      i_end_address,
    input  logic [parat_pkg::HANDLE_W-1:0]    i_area_handle,
    input  logic [parat_pkg::ADDR_W-1:0]      i_address,
    output logic                              o_res_valid,
    input  logic                              i_res_stall,
    output parat_pkg::t_result                o_res,
    output logic                              o_mem_we,
    output logic [IW-1:0]                     o_mem_waddr,
    output parat_pkg::t_range                 o_mem_wdata,
    output logic                              o_mem_re,
    output logic [IW-1:0]                     o_mem_raddr,
    input  parat_pkg::t_range                 i_mem_rdata
);
    import parat_pkg::*;

    localparam int CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_result           r_res, n_res;

    logic [CW-1:0]     ptr_inc;
    logic [CW-1:0]     count_inc;
    logic [CMPW-1:0]   handle_ext;
    logic [CMPW-1:0]   count_ext;
    logic              hit;

    assign ptr_inc    = r_ptr + CW'(1);
    assign count_inc  = r_count + CW'(1);
    assign handle_ext = CMPW'(i_area_handle);
    assign count_ext  = CMPW'(r_count);
    assign hit        = r_pend && (r_addr >= i_mem_rdata.start_addr)
                        && (r_addr <= i_mem_rdata.end_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_pend <= n_pend;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_addr      = r_addr;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr[IW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ptr[IW-1:0];
        o_res_valid = 1'b0;
        o_in_stall  = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    unique case (i_func)
                        FUNC_ADD: begin
                            if (r_count < CW'(AREAS)) begin
                                o_mem_we               = 1'b1;
                                o_mem_waddr            = r_count[IW-1:0];
                                o_mem_wdata.start_addr = i_start_address;
                                o_mem_wdata.end_addr   = i_end_address;
                                n_count                = count_inc;
                                n_res.accepted         = 1'b1;
                                n_res.new_handle       = HANDLE_W'(count_inc);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (handle_ext != '0 && handle_ext <= count_ext) begin
                                n_count        = r_count - CW'(1);
                                n_ptr          = CW'(handle_ext - CMPW'(1));
                                n_res.accepted = 1'b1;
                                n_state        = S_SHIFT_RD;
                            end
                        end
                        FUNC_CHECK: begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_addr  = i_address;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // compare last read entry while fetching the next one
                if (hit) begin
                    n_res.in_zone = 1'b1;
                    n_state       = S_DONE;
                end else if (r_ptr < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr[IW-1:0];
                    n_ptr       = ptr_inc;
                    n_pend      = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                // count already holds the reduced value
                if (r_ptr < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = ptr_inc[IW-1:0];
                    n_state     = S_SHIFT_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr[IW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_ptr       = ptr_inc;
                n_state     = S_SHIFT_RD;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

/* src/protected_address_range_table.sv */
// channel   direction   handshake                  payload
// in        input       i_in_valid / o_in_stall    i_func, i_start_address, i_end_address,
//                                                  i_area_handle, i_address
// out       output      o_out_valid / i_out_stall  o_accepted, o_new_handle, o_in_zone
//
// one item at a time; the table lives in a single-port-write ram with a registered read
// add, rejected items and undefined func: result goes from the controller's result register to the output register
// check: one ram read per cycle, stops at the first hit
// remove of handle h: one read and one write per shifted entry
// reset (synchronous, active low) empties the table; ram contents are not cleared
// a result waits in the output register under stall while the next item is taken
module protected_address_range_table #(
    parameter int AREAS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_func,
    input  logic [parat_pkg::ADDR_W-1:0]   i_start_address,
    input  logic [parat_pkg::ADDR_W-1:0]   i_end_address,
    input  logic [parat_pkg::HANDLE_W-1:0] i_area_handle,
    input  logic [parat_pkg::ADDR_W-1:0]   i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_accepted,
    output logic [parat_pkg::HANDLE_W-1:0] o_new_handle,
    output logic                           o_in_zone
);
    import parat_pkg::*;

    localparam int CW = $clog2(AREAS + 1);
    localparam int IW = (AREAS > 1) ? $clog2(AREAS) : 1;

    logic          res_valid;
    logic          res_stall;
    t_result       res;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_range        mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    t_range        mem_rdata;

    logic          r_out_valid;
    t_result       r_out;

    parat_ctrl #(
        .AREAS (AREAS),
        .CW    (CW),
        .IW    (IW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_start_address (i_start_address),
        .i_end_address   (i_end_address),
        .i_area_handle   (i_area_handle),
        .i_address       (i_address),
        .o_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    parat_ram #(
        .DEPTH (AREAS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!res_stall) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!res_stall && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out.accepted;
    assign o_new_handle = r_out.new_handle;
    assign o_in_zone    = r_out.in_zone;

endmodule

/* src/parat_chk.sv */
module parat_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_accepted,
    input logic [parat_pkg::HANDLE_W-1:0] o_new_handle,
    input logic                           o_in_zone
);
    import parat_pkg::*;

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accepted");

    // a hit is only reported by a check, which never claims success
    a_zone_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_in_zone) |-> (!o_accepted && o_new_handle == '0))
        else $error("in_zone with accepted or handle");

    // a handle comes only with a successful add
    a_handle_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_handle != '0) |-> o_accepted)
        else $error("handle without accepted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_accepted) && $stable(o_new_handle)
             && $stable(o_in_zone)))
        else $error("stalled result changed");

endmodule

bind protected_address_range_table parat_chk u_parat_chk (.*);

/* tb/testbench.sv */
module testbench;
    import parat_pkg::*;

    localparam int         AREAS          = 8;
    localparam logic [1:0] FUNC_UNDEFINED = 2'd3;
    localparam int         SHOW_LIMIT     = 10;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          in_func;
    logic [ADDR_W-1:0]   in_start;
    logic [ADDR_W-1:0]   in_end;
    logic [HANDLE_W-1:0] in_handle;
    logic [ADDR_W-1:0]   in_addr;
    logic                out_valid;
    logic                out_stall;
    logic                out_accepted;
    logic [HANDLE_W-1:0] out_new_handle;
    logic                out_in_zone;

    // table mirror used to predict each result
    logic [ADDR_W-1:0]   model_lo [AREAS];
    logic [ADDR_W-1:0]   model_hi [AREAS];
    int unsigned         model_used;

    t_result             expected_results [$];

    bit                  send_idle_en;
    bit                  recv_idle_en;
    int                  hold_left;
    int                  errors;
    int                  mismatches;
    int                  items_sent;
    int                  results_seen;
    int                  adds_ok;
    int                  adds_full;
    int                  removes_ok;
    int                  removes_bad;
    int                  zone_hits;

    protected_address_range_table #(
        .AREAS(AREAS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (in_func),
        .i_start_address(in_start),
        .i_end_address  (in_end),
        .i_area_handle  (in_handle),
        .i_address      (in_addr),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_accepted     (out_accepted),
        .o_new_handle   (out_new_handle),
        .o_in_zone      (out_in_zone)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("simulation failed");
        $finish;
    end

    function automatic t_result apply_table_op(
        input logic [1:0]          func,
        input logic [ADDR_W-1:0]   s,
        input logic [ADDR_W-1:0]   e,
        input logic [HANDLE_W-1:0] h,
        input logic [ADDR_W-1:0]   a
    );
        t_result r;
        r = '0;
        case (func)
            FUNC_ADD: begin
                if (model_used < AREAS) begin
                    model_lo[model_used] = s;
                    model_hi[model_used] = e;
                    model_used++;
                    r.accepted   = 1'b1;
                    r.new_handle = HANDLE_W'(model_used);
                    adds_ok++;
                end else begin
                    adds_full++;
                end
            end
            FUNC_REMOVE: begin
                if (h != 0 && h <= model_used) begin
                    model_used--;
                    // later entries move down by one
                    for (int i = int'(h) - 1; i < int'(model_used); i++) begin
                        model_lo[i] = model_lo[i + 1];
                        model_hi[i] = model_hi[i + 1];
                    end
                    r.accepted = 1'b1;
                    removes_ok++;
                end else begin
                    removes_bad++;
                end
            end
            FUNC_CHECK: begin
                for (int i = 0; i < int'(model_used); i++) begin
                    if (a >= model_lo[i] && a <= model_hi[i]) r.in_zone = 1'b1;
                end
                if (r.in_zone) zone_hits++;
            end
            default: ;
        endcase
        return r;
    endfunction

    // address on or just beside the edge of a range in use
    function automatic logic [ADDR_W-1:0] edge_address();
        int idx;
        if (model_used == 0) return ADDR_W'($urandom);
        idx = $urandom_range(model_used - 1);
        case ($urandom_range(3))
            0:       return model_lo[idx] - 1'b1;
            1:       return model_lo[idx];
            2:       return model_hi[idx];
            default: return model_hi[idx] + 1'b1;
        endcase
    endfunction

    task automatic send_item(
        input logic [1:0]          func,
        input logic [ADDR_W-1:0]   s,
        input logic [ADDR_W-1:0]   e,
        input logic [HANDLE_W-1:0] h,
        input logic [ADDR_W-1:0]   a
    );
        if (send_idle_en && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_func   <= func;
        in_start  <= s;
        in_end    <= e;
        in_handle <= h;
        in_addr   <= a;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(apply_table_op(func, s, e, h, a));
        items_sent++;
    endtask

    task automatic send_random_op();
        logic [1:0]          func;
        logic [ADDR_W-1:0]   s;
        logic [ADDR_W-1:0]   e;
        logic [ADDR_W-1:0]   t;
        logic [HANDLE_W-1:0] h;
        logic [ADDR_W-1:0]   a;
        logic [ADDR_W:0]     top;
        int                  pick;
        s    = ADDR_W'($urandom);
        e    = ADDR_W'($urandom);
        h    = HANDLE_W'($urandom);
        a    = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 32) begin
            func = FUNC_ADD;
            case ($urandom_range(3))
                0: ;
                1: begin
                    top = {1'b0, s} + (ADDR_W + 1)'($urandom_range(0, 255));
                    e   = top[ADDR_W] ? '1 : top[ADDR_W-1:0];
                end
                2: begin
                    // inverted range, start above end
                    if (s < e) begin
                        t = s;
                        s = e;
                        e = t;
                    end
                end
                default: e = s;
            endcase
        end else if (pick < 60) begin
            func = FUNC_REMOVE;
            if (model_used > 0 && $urandom_range(3) != 0) begin
                h = HANDLE_W'($urandom_range(1, model_used));
            end
        end else if (pick < 95) begin
            func = FUNC_CHECK;
            if ($urandom_range(1)) a = edge_address();
        end else begin
            func = FUNC_UNDEFINED;
        end
        send_item(func, s, e, h, a);
    endtask

    task automatic test_directed();
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h0000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'hffff);
        send_item(FUNC_REMOVE,    16'h0000, 16'h0000, 4'd0,  16'h0000);
        send_item(FUNC_REMOVE,    16'h0000, 16'h0000, 4'd1,  16'h0000);
        send_item(FUNC_ADD,       16'h0000, 16'h0000, 4'd0,  16'h0000);
        send_item(FUNC_ADD,       16'hffff, 16'hffff, 4'd15, 16'hffff);
        send_item(FUNC_ADD,       16'h9000, 16'h1000, 4'd0,  16'h0000);
        send_item(FUNC_ADD,       16'h1000, 16'h1fff, 4'd0,  16'h0000);
        send_item(FUNC_CHECK,     16'hffff, 16'hffff, 4'd15, 16'h0000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'hffff);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h5000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h1fff);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h2000);
        send_item(FUNC_UNDEFINED, 16'hffff, 16'hffff, 4'd15, 16'hffff);
        send_item(FUNC_ADD,       16'h4000, 16'h40ff, 4'd0,  16'h0000);
        send_item(FUNC_ADD,       16'h8000, 16'h8000, 4'd0,  16'h0000);
        send_item(FUNC_ADD,       16'hc000, 16'hcfff, 4'd0,  16'h0000);
        send_item(FUNC_ADD,       16'h0000, 16'hffff, 4'd0,  16'h0000);
        // table full
        send_item(FUNC_ADD,       16'h2000, 16'h2fff, 4'd0,  16'h0000);
        send_item(FUNC_REMOVE,    16'h0000, 16'h0000, 4'd9,  16'h0000);
        send_item(FUNC_REMOVE,    16'hffff, 16'hffff, 4'd15, 16'hffff);
        send_item(FUNC_REMOVE,    16'h0000, 16'h0000, 4'd8,  16'h0000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h5000);
        send_item(FUNC_REMOVE,    16'h0000, 16'h0000, 4'd1,  16'h0000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h0000);
        send_item(FUNC_CHECK,     16'h0000, 16'h0000, 4'd0,  16'h8000);
    endtask

    task automatic test_random_ops(input int count);
        for (int n = 0; n < count; n++) begin
            // a stretch with both sides running flat out
            if (n == count / 3) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            if (n == count / 3 + 150) begin
                send_idle_en = 1'b1;
                recv_idle_en = 1'b1;
            end
            send_random_op();
        end
    endtask

    task automatic test_output_hold();
        send_idle_en = 1'b0;
        hold_left    = 200;
        for (int n = 0; n < 24; n++) send_random_op();
        send_idle_en = 1'b1;
    endtask

    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= recv_idle_en && ($urandom_range(99) < 33);
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_result got;
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            got.accepted   = out_accepted;
            got.new_handle = out_new_handle;
            got.in_zone    = out_in_zone;
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("result with no item outstanding: acc %b handle %0d zone %b",
                         got.accepted, got.new_handle, got.in_zone);
            end else begin
                want = expected_results.pop_front();
                if (got.accepted !== want.accepted || got.new_handle !== want.new_handle ||
                    got.in_zone !== want.in_zone) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("mismatch at result %0d: want acc/handle/zone %b/%0d/%b",
                                 results_seen, want.accepted, want.new_handle, want.in_zone,
                                 " got %b/%0d/%b",
                                 got.accepted, got.new_handle, got.in_zone);
                end
            end
        end
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_func      = '0;
        in_start     = '0;
        in_end       = '0;
        in_handle    = '0;
        in_addr      = '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_left    = 0;
        errors       = 0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        adds_ok      = 0;
        adds_full    = 0;
        removes_ok   = 0;
        removes_bad  = 0;
        zone_hits    = 0;
        model_used   = 0;
        for (int i = 0; i < AREAS; i++) begin
            model_lo[i] = '0;
            model_hi[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_ops(1000);
        test_output_hold();
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d items, %0d results; adds %0d ok %0d full, removes %0d ok %0d rejected",
                 items_sent, results_seen, adds_ok, adds_full, removes_ok, removes_bad);
        $display("%0d checks hit a range, %0d mismatches, %0d errors",
                 zone_hits, mismatches, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
